>>> hw/rtl/kfq_pkg.sv
// Shared types, codes and default sizes for the keyed FIFO record queue.
`timescale 1ns / 1ps

package kfq_pkg;

  localparam int KEY_W            = 16;
  localparam int PAYLOAD_W        = 64;
  localparam int OP_W             = 3;
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [KEY_W-1:0]     search_key;
    logic [KEY_W-1:0]     record_key;
    logic [PAYLOAD_W-1:0] record_payload;
  } in_req_t;

  typedef struct packed {
    logic                 status;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } fsm_state_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_DATA
  } res_kind_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_t;

  typedef struct packed {
    logic      req_load;
    logic      idx_inc;
    logic      count_inc;
    logic      count_dec;
    logic      wr_en;
    logic      wr_tail;
    logic      wr_from_ram;
    rd_sel_t   rd_sel;
    logic      res_en;
    res_kind_t res_kind;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            full;
    logic            key_match;
    logic            last;
    logic            shift_more;
    logic            out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/kfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/kfq_ctrl.sv
// Controller state machine that sequences each request through decode and, as its operation needs, scan and shift.
`timescale 1ns / 1ps

module kfq_ctrl
  import kfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  fsm_state_t state_r;
  fsm_state_t state_nxt;
  logic       hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign hit = (stat.op == OP_POP) || stat.key_match;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = RD_ZERO;
    cmd.res_kind = RES_FAIL;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_en = 1'b1;
        state_nxt  = ST_DONE;
        case (stat.op)
          OP_PUSH: begin
            if (!stat.full) begin
              cmd.wr_en     = 1'b1;
              cmd.wr_tail   = 1'b1;
              cmd.count_inc = 1'b1;
              cmd.res_kind  = RES_OK;
            end
          end
          OP_POP, OP_MODIFY, OP_LOOKUP, OP_REMOVE: begin
            if (!stat.count_zero) begin
              cmd.res_en = 1'b0;
              state_nxt  = ST_SCAN;
            end
          end
          default: begin
            cmd.res_kind = RES_FAIL;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.rd_sel = RD_NEXT;
        if (hit) begin
          cmd.res_en = 1'b1;
          case (stat.op)
            OP_POP: begin
              cmd.res_kind = RES_DATA;
              state_nxt    = ST_SHIFT;
            end
            OP_LOOKUP: begin
              cmd.res_kind = RES_DATA;
              state_nxt    = ST_DONE;
            end
            OP_MODIFY: begin
              cmd.wr_en    = 1'b1;
              cmd.res_kind = RES_OK;
              state_nxt    = ST_DONE;
            end
            default: begin
              cmd.res_kind = RES_OK;
              state_nxt    = ST_SHIFT;
            end
          endcase
        end else if (stat.last) begin
          cmd.res_en = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.rd_sel = RD_NEXT2;
        if (stat.shift_more) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_from_ram = 1'b1;
          cmd.idx_inc     = 1'b1;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/kfq_dpath.sv
// Datapath with request register, record memory, index and count, and result and output registers.
`timescale 1ns / 1ps

module kfq_dpath
  import kfq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_rsp_t  out_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = KEY_W + PAYLOAD_BITS;

  in_req_t           req_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     idx_r;
  out_rsp_t          res_r;
  out_rsp_t          res_nxt;
  out_rsp_t          out_data_r;
  logic              out_valid_r;

  logic [SW-1:0]     idx_p1;
  logic [SW-1:0]     idx_p2;
  logic [SW-1:0]     count_ext;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;
  logic [KEY_W-1:0]  rd_key;

  assign idx_p1    = SW'(idx_r) + SW'(1);
  assign idx_p2    = SW'(idx_r) + SW'(2);
  assign count_ext = SW'(count_r);
  assign rd_key    = rd_data[EW-1:PAYLOAD_BITS];

  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT:  rd_addr = (idx_p1 < SW'(QUEUE_DEPTH)) ? idx_p1[AW-1:0] : '0;
      RD_NEXT2: rd_addr = (idx_p2 < SW'(QUEUE_DEPTH)) ? idx_p2[AW-1:0] : '0;
      default:  rd_addr = '0;
    endcase
  end

  assign wr_addr = cmd.wr_tail ? count_r[AW-1:0] : idx_r;
  assign wr_data = cmd.wr_from_ram ? rd_data
                                   : {req_r.record_key, req_r.record_payload[PAYLOAD_BITS-1:0]};

  kfq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    res_nxt = '0;
    case (cmd.res_kind)
      RES_OK: begin
        res_nxt.status = 1'b0;
      end
      RES_DATA: begin
        res_nxt.status      = 1'b0;
        res_nxt.out_key     = rd_key;
        res_nxt.out_payload = PAYLOAD_W'(rd_data[PAYLOAD_BITS-1:0]);
      end
      default: begin
        res_nxt.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      out_valid_r <= cmd.out_load | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_data;
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.res_en) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign stat.op         = req_r.operation;
  assign stat.count_zero = (count_r == '0);
  assign stat.full       = (count_r == CW'(QUEUE_DEPTH));
  assign stat.key_match  = (rd_key == req_r.search_key);
  assign stat.last       = (idx_p1 == count_ext);
  assign stat.shift_more = (idx_p1 < count_ext);
  assign stat.out_free   = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/keyed_fifo_record_queue_unit.sv
// Top level of the keyed FIFO record queue: controller plus datapath.
// Push and requests failing on an empty or full queue go from decode straight to the done state.
// Lookup, modify and remove scan from the head until the key matches or the last record misses;
// pop takes the head, and pop and remove then shift later records down, one entry per cycle.
// One request is in flight at a time; a waiting response lets the next request in only.
// Synchronous reset empties the queue; record storage is not cleared and needs no sweep.
`timescale 1ns / 1ps

module keyed_fifo_record_queue_unit
  import kfq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  kfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kfq_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
